/* hdl/wfm_pkg.sv */
// Shared types and constants for the whitespace-filtered hash block.
package wfm_pkg;

  localparam int unsigned MAX_WORDS = 4096;
  localparam int unsigned ADDR_W    = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned WCNT_W    = $clog2(MAX_WORDS + 1);

  localparam int unsigned QDEPTH  = 4;
  localparam int unsigned QPTR_W  = $clog2(QDEPTH);
  localparam int unsigned QCNT_W  = $clog2(QDEPTH + 1);

  localparam logic [31:0] MIX_MUL = 32'd1540483477;

  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } wfm_req_t;

  typedef struct packed {
    logic [31:0] hash_value;
    logic        too_long;
  } wfm_res_t;

  // One queued byte: keep marks a byte that goes into the hash.
  typedef struct packed {
    logic       keep;
    logic [7:0] data;
    logic       last;
  } wfm_item_t;

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

endpackage

/* hdl/whitespace_filtered_murmur2_hash.sv */
// Top level of the whitespace-filtered 32-bit MurmurHash2 fingerprint block.
//
// Usage: a file is fed as byte requests on req_i, one per cycle, taken at a
// rising edge where start is high and busy is low. req_i.last_byte marks the
// final byte. Tab, line feed, carriage return and space are dropped; other
// bytes are packed little-endian into 32-bit words in a 4096-word store.
// After the final byte the engine walks the stored words and emits one
// result on res_o, flagged by done_o for exactly one cycle. There is no
// back-pressure on results: the receiver must take it in that cycle.
// Throughput: one byte per cycle while the four-entry request queue has
// room; the engine packs one byte a cycle except while it walks the store.
// After the last byte reaches the engine: a start step, then for each stored
// word a memory read, two key multiplies and a hash multiply on the one
// shared multiplier, then tail and final mixing; on overflow the start step
// gives too_long with a zero hash. busy stays high while the queue is full.
// Reset: queue empty, packing state cleared; the word store is not cleared
// as only words written for the current file are read back.
module whitespace_filtered_murmur2_hash (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  wfm_pkg::wfm_req_t req_i,
  output logic              busy,
  output logic              done_o,
  output wfm_pkg::wfm_res_t res_o
);
  import wfm_pkg::*;

  logic              push, pop, q_empty, q_full;
  wfm_item_t         push_item, head_item;
  logic [QCNT_W-1:0] q_cnt;

  // Front: classify and drop blank non-final bytes before queueing.
  wfm_front u_front (
    .start  (start),
    .req_i  (req_i),
    .full_i (q_full),
    .busy   (busy),
    .push_o (push),
    .item_o (push_item)
  );

  // Request queue decouples byte intake from the hash walk.
  wfm_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_item),
    .pop_i       (pop),
    .head_o      (head_item),
    .empty_o     (q_empty),
    .full_o      (q_full),
    .count_o     (q_cnt)
  );

  // Back: packing, word store and the final mixing walk.
  wfm_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .head_i  (head_item),
    .empty_i (q_empty),
    .pop_o   (pop),
    .done_o  (done_o),
    .res_o   (res_o)
  );

`ifndef ASSERT_OFF
  // A result strobe is always a single pulse, never held high.
  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");

  // An overflowed file reports a zero hash.
  a_overflow_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.too_long) |-> (res_o.hash_value == 32'd0))
    else $error("too_long result with nonzero hash");

  // Queue occupancy stays within its depth.
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_cnt <= QCNT_W'(QDEPTH)) else $error("request queue overrun");
`endif

endmodule

/* hdl/wfm_front.sv */
// Front end: takes byte requests, classifies them and queues the useful ones.
module wfm_front (
  input  logic              start,
  input  wfm_pkg::wfm_req_t req_i,
  input  logic              full_i,
  output logic              busy,
  output logic              push_o,
  output wfm_pkg::wfm_item_t item_o
);
  import wfm_pkg::*;

  logic blank;

  assign blank = is_blank(req_i.data_byte);
  assign busy  = full_i;

  // Blank bytes that do not end a file carry nothing; they are swallowed here.
  assign push_o      = start && !full_i && (!blank || req_i.last_byte);
  assign item_o.keep = !blank;
  assign item_o.data = req_i.data_byte;
  assign item_o.last = req_i.last_byte;

endmodule

/* hdl/wfm_fifo.sv */
// Short queue between the front end and the hash engine.
module wfm_fifo (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  wfm_pkg::wfm_item_t           push_data_i,
  input  logic                         pop_i,
  output wfm_pkg::wfm_item_t           head_o,
  output logic                         empty_o,
  output logic                         full_o,
  output logic [wfm_pkg::QCNT_W-1:0]   count_o
);
  import wfm_pkg::*;

  wfm_item_t         slots_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QDEPTH));
  assign count_o = cnt_q;
  assign head_o  = slots_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = wr_q + QPTR_W'(1);
    end
    if (pop_i) begin
      rd_d = rd_q + QPTR_W'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* hdl/wfm_back.sv */
// Hash engine: packs kept bytes into the word store and walks it at end of file.
module wfm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wfm_pkg::wfm_item_t head_i,
  input  logic               empty_i,
  output logic               pop_o,
  output logic               done_o,
  output wfm_pkg::wfm_res_t  res_o
);
  import wfm_pkg::*;

  localparam logic [3:0] S_RUN   = 4'd0;
  localparam logic [3:0] S_START = 4'd1;
  localparam logic [3:0] S_RD    = 4'd2;
  localparam logic [3:0] S_K1    = 4'd3;
  localparam logic [3:0] S_K2    = 4'd4;
  localparam logic [3:0] S_HM    = 4'd5;
  localparam logic [3:0] S_TAIL  = 4'd6;
  localparam logic [3:0] S_FIN1  = 4'd7;
  localparam logic [3:0] S_FIN2  = 4'd8;

  logic [31:0] mem [MAX_WORDS];
  logic [31:0] rdata_q;

  logic [3:0]        state_q, state_d;
  logic [31:0]       partial_q, partial_d;
  logic [1:0]        slot_q, slot_d;
  logic [WCNT_W-1:0] wcnt_q, wcnt_d;
  logic              ovf_q, ovf_d;
  logic [WCNT_W-1:0] idx_q, idx_d;
  logic [31:0]       h_q, h_d;
  logic [31:0]       t_q, t_d;
  logic              done_q, done_d;
  wfm_res_t          res_q, res_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0]       wdata;
  logic [31:0]       mul_a, prod;

  assign pop_o  = (state_q == S_RUN) && !empty_i;
  assign done_o = done_q;
  assign res_o  = res_q;

  // Single shared multiplier, operand picked by the walk step.
  always_comb begin
    case (state_q)
      S_K1:    mul_a = rdata_q;
      S_K2:    mul_a = t_q ^ (t_q >> 24);
      S_HM:    mul_a = h_q;
      S_TAIL:  mul_a = h_q ^ partial_q;
      S_FIN1:  mul_a = h_q ^ (h_q >> 13);
      default: mul_a = h_q;
    endcase
  end
  assign prod = mul_a * MIX_MUL;

  always_comb begin
    state_d   = state_q;
    partial_d = partial_q;
    slot_d    = slot_q;
    wcnt_d    = wcnt_q;
    ovf_d     = ovf_q;
    idx_d     = idx_q;
    h_d       = h_q;
    t_d       = t_q;
    done_d    = 1'b0;
    res_d     = res_q;
    we        = 1'b0;
    waddr     = wcnt_q[ADDR_W-1:0];
    wdata     = {head_i.data, partial_q[23:0]};

    case (state_q)
      S_RUN: begin
        if (pop_o) begin
          if (head_i.keep) begin
            slot_d = slot_q + 2'd1;
            case (slot_q)
              2'd0:    partial_d = {24'd0, head_i.data};
              2'd1:    partial_d = {16'd0, head_i.data, partial_q[7:0]};
              2'd2:    partial_d = {8'd0, head_i.data, partial_q[15:0]};
              default: begin
                partial_d = '0;
                if (ovf_q || (wcnt_q == WCNT_W'(MAX_WORDS))) begin
                  ovf_d = 1'b1;
                end else begin
                  we     = 1'b1;
                  wcnt_d = wcnt_q + WCNT_W'(1);
                end
              end
            endcase
          end
          if (head_i.last) begin
            state_d = S_START;
          end
        end
      end
      S_START: begin
        idx_d = '0;
        h_d   = 32'd1 ^ 32'({wcnt_q, slot_q});
        if (ovf_q) begin
          done_d           = 1'b1;
          res_d.hash_value = '0;
          res_d.too_long   = 1'b1;
          partial_d        = '0;
          slot_d           = '0;
          wcnt_d           = '0;
          ovf_d            = 1'b0;
          state_d          = S_RUN;
        end else if (wcnt_q == '0) begin
          state_d = S_TAIL;
        end else begin
          state_d = S_RD;
        end
      end
      S_RD: begin
        state_d = S_K1;
      end
      S_K1: begin
        t_d     = prod;
        state_d = S_K2;
      end
      S_K2: begin
        t_d     = prod;
        state_d = S_HM;
      end
      S_HM: begin
        h_d = prod ^ t_q;
        if ((idx_q + WCNT_W'(1)) == wcnt_q) begin
          state_d = S_TAIL;
        end else begin
          idx_d   = idx_q + WCNT_W'(1);
          state_d = S_RD;
        end
      end
      S_TAIL: begin
        if (slot_q != 2'd0) begin
          h_d = prod;
        end
        state_d = S_FIN1;
      end
      S_FIN1: begin
        h_d     = prod;
        state_d = S_FIN2;
      end
      S_FIN2: begin
        done_d           = 1'b1;
        res_d.hash_value = h_q ^ (h_q >> 15);
        res_d.too_long   = 1'b0;
        partial_d        = '0;
        slot_d           = '0;
        wcnt_d           = '0;
        ovf_d            = 1'b0;
        state_d          = S_RUN;
      end
      default: begin
        state_d = S_RUN;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_RUN;
      partial_q <= '0;
      slot_q    <= '0;
      wcnt_q    <= '0;
      ovf_q     <= 1'b0;
      idx_q     <= '0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      partial_q <= partial_d;
      slot_q    <= slot_d;
      wcnt_q    <= wcnt_d;
      ovf_q     <= ovf_d;
      idx_q     <= idx_d;
      done_q    <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    h_q   <= h_d;
    t_q   <= t_d;
    res_q <= res_d;
  end

  // Word store: one write port from packing, one registered read port for the walk.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[idx_q[ADDR_W-1:0]];
  end

endmodule

/* dv/testbench.sv */
// Self-checking testbench for the whitespace-filtered MurmurHash2 fingerprint block.
`timescale 1ns / 1ps

module testbench;
  import wfm_pkg::*;

  // One row of the directed table. A pinned row carries its hash typed in by
  // hand. Every other row is checked against the fingerprint predictor.
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       pinned;
    wfm_res_t   want;
  } probe_row_t;

  // Empty file (nothing kept): seed 1, tail skipped, avalanche only.
  localparam wfm_res_t EMPTY_FILE  = '{hash_value: 32'h5BD15E36, too_long: 1'b0};
  localparam wfm_res_t NO_PIN      = '0;
  localparam int       DIR_COUNT   = 23;
  localparam int       RANDOM_REQS = 1200;
  // The longest quiet stretch is the walk over a full store. The limit
  // is a few times that.
  localparam int       QUIET_LIMIT = 60000;

  localparam probe_row_t DIR_ROWS [0:DIR_COUNT-1] = '{
    '{CH_SPACE, 1'b1, 1'b1, EMPTY_FILE},  // blank only, straight after reset
    '{8'h00,    1'b1, 1'b0, NO_PIN},      // single zero byte, one-byte tail
    '{8'hFF,    1'b1, 1'b0, NO_PIN},      // single all-ones byte
    '{8'h61,    1'b0, 1'b0, NO_PIN},      // each blank between kept bytes
    '{CH_TAB,   1'b0, 1'b0, NO_PIN},
    '{8'h62,    1'b0, 1'b0, NO_PIN},
    '{CH_LF,    1'b0, 1'b0, NO_PIN},
    '{8'h63,    1'b0, 1'b0, NO_PIN},
    '{CH_CR,    1'b0, 1'b0, NO_PIN},
    '{8'h64,    1'b0, 1'b0, NO_PIN},
    '{CH_SPACE, 1'b0, 1'b0, NO_PIN},
    '{8'h65,    1'b1, 1'b0, NO_PIN},      // one word plus a one-byte tail
    '{8'hFF,    1'b0, 1'b0, NO_PIN},      // exactly one word, no tail
    '{8'h00,    1'b0, 1'b0, NO_PIN},
    '{8'hFF,    1'b0, 1'b0, NO_PIN},
    '{8'h00,    1'b1, 1'b0, NO_PIN},
    '{CH_TAB,   1'b1, 1'b1, EMPTY_FILE},  // blank only, after a full file
    '{8'h80,    1'b0, 1'b0, NO_PIN},      // three-byte tail, blank final byte
    '{8'h7F,    1'b0, 1'b0, NO_PIN},
    '{8'h01,    1'b0, 1'b0, NO_PIN},
    '{CH_LF,    1'b1, 1'b0, NO_PIN},
    '{8'h08,    1'b0, 1'b0, NO_PIN},      // neighbours of the blank codes
    '{8'h21,    1'b1, 1'b0, NO_PIN}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni;
  logic     start;
  wfm_req_t req_i;
  logic     busy;
  logic     done_o;
  wfm_res_t res_o;

  // Predictor state: a private copy of the packing and the word store
  logic [31:0] word_copy [MAX_WORDS];
  logic [31:0] pack_word    = '0;
  logic [1:0]  pack_slot    = '0;
  logic [31:0] kept_bytes   = '0;
  logic        store_full   = 1'b0;

  wfm_res_t    hash_due [$];   // hashes still outstanding, oldest first
  wfm_res_t    oldest_due;
  int          mismatches   = 0;
  int          reqs_sent    = 0;
  int          files_sent   = 0;
  int          hashes_seen  = 0;
  int          overflow_hits = 0;
  int          quiet_cycles = 0;
  bit          no_idle      = 1'b0;

  whitespace_filtered_murmur2_hash dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .req_i  (req_i),
    .busy   (busy),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic bit drops_byte(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_LF) || (c == CH_CR) || (c == CH_SPACE);
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(3))
      0: return CH_TAB;
      1: return CH_LF;
      2: return CH_CR;
      default: return CH_SPACE;
    endcase
  endfunction

  function automatic logic [7:0] kept_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255)); while (drops_byte(c));
    return c;
  endfunction

  // Seed with the kept count, mix the stored words, fold in the tail, then
  // apply the final avalanche. All products wrap at 32 bits.
  function automatic logic [31:0] fingerprint();
    logic [31:0] h;
    logic [31:0] k;
    int unsigned n;
    int unsigned i;
    h = 32'd1 ^ kept_bytes;
    n = kept_bytes >> 2;
    if (n > MAX_WORDS) n = MAX_WORDS;
    for (i = 0; i < n; i++) begin
      k = word_copy[i[ADDR_W-1:0]] * MIX_MUL;
      k = (k ^ (k >> 24)) * MIX_MUL;
      h = (h * MIX_MUL) ^ k;
    end
    if (pack_slot != 2'd0) h = (h ^ pack_word) * MIX_MUL;
    h = (h ^ (h >> 13)) * MIX_MUL;
    return h ^ (h >> 15);
  endfunction

  // Advance the predictor by one request. Returns 1 when the request closes a
  // file, with the expected hash in res.
  function automatic bit predict_fingerprint(input wfm_req_t rq, output wfm_res_t res);
    logic [31:0] idx;
    res = '0;
    if (!drops_byte(rq.data_byte)) begin
      pack_word  = pack_word | ({24'd0, rq.data_byte} << (8 * pack_slot));
      pack_slot  = pack_slot + 2'd1;
      kept_bytes = kept_bytes + 32'd1;
      if (pack_slot == 2'd0) begin
        idx = (kept_bytes >> 2) - 32'd1;
        // Once the store has overflowed, later words are dropped as well
        if (store_full || idx >= MAX_WORDS || (kept_bytes >> 2) == 32'd0) begin
          store_full = 1'b1;
        end else begin
          word_copy[idx[ADDR_W-1:0]] = pack_word;
        end
        pack_word = '0;
      end
    end
    if (!rq.last_byte) return 1'b0;
    if (store_full) begin
      res.hash_value = '0;
      res.too_long   = 1'b1;
    end else begin
      res.hash_value = fingerprint();
      res.too_long   = 1'b0;
    end
    pack_word  = '0;
    pack_slot  = '0;
    kept_bytes = '0;
    store_full = 1'b0;
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("MISMATCH %s: got %h, expected %h at %0t", what, got, want, $realtime);
    mismatches++;
  endtask

  // Issue one request and hold it until it is taken. Entered and left just
  // after a rising edge. start is left high, so that the next request can
  // follow with no gap.
  task automatic send_req(input logic [7:0] b, input logic lst, input logic pin,
                          input wfm_res_t want);
    int       gap;
    wfm_req_t rq;
    wfm_res_t due;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    rq.data_byte = b;
    rq.last_byte = lst;
    start <= 1'b1;
    req_i <= rq;
    // busy read here is its value before this edge, which is the one that
    // decides whether the request is taken
    do @(posedge clk_i); while (busy);
    reqs_sent++;
    if (predict_fingerprint(rq, due)) begin
      hash_due.push_back(pin ? want : due);
      files_sent++;
    end
  endtask

  // One file with n_kept kept bytes and blanks scattered among them. The final
  // byte is a kept byte unless blank_end is set or nothing is kept.
  task automatic send_file(input int unsigned n_kept, input int unsigned blank_pct,
                           input bit blank_end);
    int unsigned kept;
    kept = 0;
    while (kept < n_kept) begin
      if ($urandom_range(99) < blank_pct) begin
        send_req(blank_char(), 1'b0, 1'b0, NO_PIN);
      end else begin
        kept++;
        send_req(kept_char(), (kept == n_kept) && !blank_end, 1'b0, NO_PIN);
      end
    end
    if (blank_end || n_kept == 0) send_req(blank_char(), 1'b1, 1'b0, NO_PIN);
  endtask

  // Hold requests back until every outstanding hash has arrived
  task automatic drain_hashes();
    start <= 1'b0;
    while (hash_due.size() != 0) @(posedge clk_i);
  endtask

  // Results are on the ports for one cycle. Sample them at the edge that ends
  // that cycle.
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (hash_due.size() == 0) begin
        report_mismatch("hash with none outstanding", res_o.hash_value, '0);
      end else begin
        oldest_due = hash_due.pop_front();
        hashes_seen++;
        if (oldest_due.too_long) overflow_hits++;
        if (res_o.hash_value !== oldest_due.hash_value)
          report_mismatch("hash_value", res_o.hash_value, oldest_due.hash_value);
        if (res_o.too_long !== oldest_due.too_long)
          report_mismatch("too_long", 32'(res_o.too_long), 32'(oldest_due.too_long));
      end
    end
  end

  // Watchdog: too long with neither a request taken nor a hash delivered
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("watchdog: no progress for %0d cycles, %0d hashes outstanding",
               QUIET_LIMIT, hash_due.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start  = 1'b0;
    req_i  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: blanks, extremes, word and tail boundaries
    for (int i = 0; i < DIR_COUNT; i++)
      send_req(DIR_ROWS[i].data, DIR_ROWS[i].last, DIR_ROWS[i].pinned, DIR_ROWS[i].want);
    drain_hashes();

    // Random files. Most are short, a few run to a couple of hundred bytes.
    // Some end on a blank and some keep nothing at all. Runs of back-to-back
    // requests alternate with runs of random gaps.
    while (reqs_sent < DIR_COUNT + RANDOM_REQS) begin
      if ($urandom_range(3) == 0) no_idle = ~no_idle;
      send_file(($urandom_range(9) == 0) ? $urandom_range(21, 200) : $urandom_range(0, 20),
                $urandom_range(0, 50), $urandom_range(4) == 0);
      if ($urandom_range(7) == 0) drain_hashes();
    end

    // Store exactly full with a three-byte tail, then one word past the end.
    // A small file follows to show that the overflow flag has cleared.
    no_idle = 1'b1;
    send_file(MAX_WORDS * 4 + 3, 3, 1'b0);
    no_idle = 1'b0;
    send_file(MAX_WORDS * 4 + 4, 3, 1'b1);
    send_file(6, 20, 1'b0);

    drain_hashes();
    repeat (20) @(posedge clk_i);
    if (hash_due.size() != 0)
      report_mismatch("hashes never delivered", 32'(hash_due.size()), '0);

    $display("Sent %0d byte requests in %0d files; %0d hashes checked, %0d with overflow.",
             reqs_sent, files_sent, hashes_seen, overflow_hits);
    $display("Covered blank-only files, every tail length and a full then overflowing store.");
    if (mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
